@@ src/sssf_pkg.sv @@
// Shared types, constants and the BCD segment decoder for the seven-segment scan block.
package sssf_pkg;

	// Item kinds carried on the input tuser
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_TOGGLE = 2'd1,
		OP_TICK   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_DIGIT_COUNT  = 2'd0,
		REG_FLASH_FIRST  = 2'd1,
		REG_FLASH_LAST   = 2'd2,
		REG_FLASH_PERIOD = 2'd3
	} reg_idx_t;

	localparam int COUNT_W    = 5;   // holds an effective digit count up to 16
	localparam int DCOUNT_W   = 4;
	localparam int SEG_W      = 8;
	localparam int SEL_W      = 3;
	localparam int POS_W      = 3;
	localparam int BCD_W      = 4;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DCOUNT_RST = 8;

	// Output skid buffer
	localparam int OBUF_DEPTH = 4;
	localparam int OBUF_PTR_W = 2;
	localparam int OBUF_CNT_W = 3;

	localparam logic [SEG_W-1:0] DOT_BIT   = 8'h80;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

	// Decoded item handed from the scan/control stage to the store pipeline
	typedef struct packed {
		op_t              op;
		logic             start;
		logic             wr_ok;
		logic             tog_ok;
		logic [SEG_W-1:0] wr_seg;
		logic             blank;
		logic [SEL_W-1:0] sel;
	} item_t;

	// One result beat: select above segments
	typedef struct packed {
		logic [SEL_W-1:0] sel;
		logic [SEG_W-1:0] seg;
	} out_beat_t;

	// BCD to segments a..g on bits 0..6; non-decimal codes are blank
	function automatic logic [SEG_W-1:0] seg_decode(input logic [BCD_W-1:0] bcd);
		logic [SEG_W-1:0] seg;
		case (bcd)
			4'd0: seg = 8'h3F;
			4'd1: seg = 8'h06;
			4'd2: seg = 8'h5B;
			4'd3: seg = 8'h4F;
			4'd4: seg = 8'h66;
			4'd5: seg = 8'h6D;
			4'd6: seg = 8'h7D;
			4'd7: seg = 8'h07;
			4'd8: seg = 8'h7F;
			4'd9: seg = 8'h67;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

@@ src/seven_segment_scan_flash.sv @@
// Top level of the multiplexed seven-segment scan and flash controller.
//
// Input stream (s_*): one beat per command. tuser carries the command kind
// (write BCD digit, toggle dot, refresh tick); tdata carries the digit
// position, BCD value and start-of-number flag. Only ticks produce output.
// Output stream (m_*): one beat per tick with the scanned digit's segment
// pattern and its select index.
// Configuration (cfg_*): register index and data; always ready, takes effect
// the cycle after the beat. Write it only while no commands are in flight.
// Throughput: one command per cycle while s_tready is high. The digit store is a
// one-port-read, one-port-write memory with a registered read port; a write-back to the
// entry read by the next command is forwarded, so there are no bubbles.
// Path: a tick result is registered in stage 1 and then queued in the output buffer.
// Stall: results queue in a four-entry buffer; s_tready drops only when
// that buffer plus the tick in flight would fill it.
// Reset: the store reads as all blank, digit count is 8 (clamped to
// MAX_DIGITS), scan sits at the last digit and flashing is off.
module seven_segment_scan_flash import sssf_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input commands
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // [2:0] digit_position, [6:3] bcd_value,
	                                         // [7] start_number
	input  logic [1:0]            s_tuser,   // [1:0] operation
	// Scan results
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // [7:0] segments, [10:8] digit_select,
	                                         // [15:11] zero
	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int RW = OBUF_CNT_W + 1;

	logic                  in_acc;
	item_t                 item;
	logic [AW-1:0]         addr;
	logic                  res_valid;
	out_beat_t             res;
	logic                  s1_tick;
	out_beat_t             out_beat;
	logic [OBUF_CNT_W-1:0] obuf_cnt;
	logic                  pop;

	// Handshakes
	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (RW'(obuf_cnt) + RW'(s1_tick)) < RW'(OBUF_DEPTH);
	assign pop       = m_tvalid && m_tready;
	assign m_tdata   = {5'b0, out_beat};

	sssf_ctrl #(
		.MAX_DIGITS (MAX_DIGITS),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_acc    (in_acc),
		.op        (op_t'(s_tuser)),
		.pos       (s_tdata[2:0]),
		.bcd       (s_tdata[6:3]),
		.start     (s_tdata[7]),
		.item      (item),
		.addr      (addr)
	);

	sssf_store #(
		.MAX_DIGITS (MAX_DIGITS),
		.AW         (AW)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.item      (item),
		.addr      (addr),
		.res_valid (res_valid),
		.res       (res),
		.s1_tick   (s1_tick)
	);

	sssf_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.din       (res),
		.pop       (pop),
		.dout      (out_beat),
		.not_empty (m_tvalid),
		.cnt       (obuf_cnt)
	);

endmodule

@@ src/sssf_ctrl.sv @@
// Configuration registers, scan pointer, flash counter and item decode.
module sssf_ctrl import sssf_pkg::*; #(
	parameter int MAX_DIGITS = 8,
	parameter int AW         = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_acc,
	input  op_t                   op,
	input  logic [POS_W-1:0]      pos,
	input  logic [BCD_W-1:0]      bcd,
	input  logic                  start,
	output item_t                 item,
	output logic [AW-1:0]         addr
);

	localparam logic [COUNT_W-1:0] MAX_C   = COUNT_W'(MAX_DIGITS);
	localparam int                 RST_EFF = (DCOUNT_RST > MAX_DIGITS) ? MAX_DIGITS
	                                                                   : DCOUNT_RST;
	localparam logic [AW-1:0]      SCAN_RST = AW'(RST_EFF - 1);

	logic [DCOUNT_W-1:0] dcount_q;
	logic [POS_W-1:0]    first_q;
	logic [POS_W-1:0]    last_q;
	logic [PERIOD_W-1:0] period_q;
	logic [AW-1:0]       scan_q;
	logic [PERIOD_W-1:0] ctr_q;

	logic [COUNT_W-1:0]  eff;
	logic [COUNT_W-1:0]  scan_inc;
	logic [AW-1:0]       scan_nxt;
	logic [COUNT_W-1:0]  scan_ext;
	logic [PERIOD_W:0]   ctr_inc;
	logic [PERIOD_W-1:0] ctr_wrap;
	logic [PERIOD_W-1:0] ctr_nxt;
	logic                flash_on;
	logic [COUNT_W-1:0]  pos_ext;
	logic [AW-1:0]       cfg_scan;

	// Clamp a digit count to 1..MAX_DIGITS
	function automatic logic [COUNT_W-1:0] eff_count(input logic [DCOUNT_W-1:0] dc);
		logic [COUNT_W-1:0] c;
		c = COUNT_W'(dc);
		if (c == '0)
			c = COUNT_W'(1);
		else if (c > MAX_C)
			c = MAX_C;
		return c;
	endfunction

	// Next scan position and flash counter for a tick, and the scan position for a digit-count write
	always_comb begin
		eff      = eff_count(dcount_q);
		scan_inc = COUNT_W'(scan_q) + COUNT_W'(1);
		scan_nxt = (scan_inc >= eff) ? '0 : scan_inc[AW-1:0];
		scan_ext = COUNT_W'(scan_nxt);
		flash_on = (period_q != '0);
		ctr_inc  = (PERIOD_W+1)'(ctr_q) + (PERIOD_W+1)'(1);
		ctr_wrap = (ctr_inc == {1'b0, period_q}) ? '0 : ctr_inc[PERIOD_W-1:0];
		ctr_nxt  = (flash_on && scan_nxt == '0) ? ctr_wrap : ctr_q;
		pos_ext  = COUNT_W'(pos);
		cfg_scan = AW'(eff_count(cfg_data[DCOUNT_W-1:0]) - COUNT_W'(1));
	end

	// Item decode for the store pipeline
	always_comb begin
		item.op     = op;
		item.start  = start;
		item.wr_ok  = (pos_ext < eff);
		item.tog_ok = (pos_ext < MAX_C);
		item.wr_seg = seg_decode(bcd);
		item.blank  = flash_on && (COUNT_W'(first_q) <= scan_ext)
		              && (scan_ext <= COUNT_W'(last_q))
		              && (ctr_nxt > (period_q >> 1));
		item.sel    = scan_ext[SEL_W-1:0];
		addr        = (op == OP_TICK) ? scan_nxt : pos_ext[AW-1:0];
	end

	// Register file, scan pointer and flash counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcount_q <= DCOUNT_W'(DCOUNT_RST);
			first_q  <= '0;
			last_q   <= '0;
			period_q <= '0;
			scan_q   <= SCAN_RST;
			ctr_q    <= '0;
		end else if (cfg_wr) begin
			case (reg_idx_t'(cfg_index))
				REG_DIGIT_COUNT: begin
					dcount_q <= cfg_data[DCOUNT_W-1:0];
					scan_q   <= cfg_scan;
				end
				REG_FLASH_FIRST: first_q <= cfg_data[POS_W-1:0];
				REG_FLASH_LAST:  last_q  <= cfg_data[POS_W-1:0];
				REG_FLASH_PERIOD: begin
					period_q <= cfg_data[PERIOD_W-1:0];
					ctr_q    <= '0;
				end
				default: ;
			endcase
		end else if (in_acc && op == OP_TICK) begin
			scan_q <= scan_nxt;
			ctr_q  <= ctr_nxt;
		end
	end

endmodule

@@ src/sssf_store.sv @@
// Digit store memory with read-modify-write pipeline, valid bits and forwarding.
module sssf_store import sssf_pkg::*; #(
	parameter int MAX_DIGITS = 8,
	parameter int AW         = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_acc,
	input  item_t         item,
	input  logic [AW-1:0] addr,
	output logic          res_valid,
	output out_beat_t     res,
	output logic          s1_tick
);

	logic [SEG_W-1:0]      mem [MAX_DIGITS];
	logic [MAX_DIGITS-1:0] valid_q;

	logic                  vld_s1;
	item_t                 item_s1;
	logic [AW-1:0]         addr_s1;
	logic [SEG_W-1:0]      rd_data_s1;
	logic                  fwd_s1;
	logic [SEG_W-1:0]      fwd_data_s1;

	logic [SEG_W-1:0]      cur;
	logic                  wr_en;
	logic [SEG_W-1:0]      wr_data;
	logic                  is_write;

	// Current entry value: forwarded write, stored data, or zero if not written since reset or the last new number
	always_comb begin
		if (fwd_s1)
			cur = fwd_data_s1;
		else if (valid_q[addr_s1])
			cur = rd_data_s1;
		else
			cur = SEG_BLANK;
		is_write = vld_s1 && (item_s1.op == OP_WRITE);
		wr_en    = (is_write && item_s1.wr_ok)
		           || (vld_s1 && item_s1.op == OP_TOGGLE && item_s1.tog_ok);
		wr_data  = (item_s1.op == OP_WRITE) ? item_s1.wr_seg : (cur ^ DOT_BIT);
	end

	// Tick result
	always_comb begin
		s1_tick   = vld_s1 && (item_s1.op == OP_TICK);
		res_valid = s1_tick;
		res.seg   = item_s1.blank ? SEG_BLANK : cur;
		res.sel   = item_s1.sel;
	end

	// Memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr_s1] <= wr_data;
		if (in_acc)
			rd_data_s1 <= mem[addr];
	end

	// Stage 1 payload and same-entry forwarding
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item;
			addr_s1 <= addr;
		end
		fwd_data_s1 <= wr_data;
	end

	// Stage valid, forward flag and entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			fwd_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			vld_s1 <= in_acc;
			fwd_s1 <= wr_en && (addr_s1 == addr);
			// a new number clears every entry but the one it writes, or all of them if its position is out of range
			if (is_write && item_s1.start) begin
				valid_q <= item_s1.wr_ok ? (MAX_DIGITS'(1) << addr_s1) : '0;
			end else if (wr_en) begin
				valid_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

@@ src/sssf_obuf.sv @@
// Small output queue that decouples the result stream from the store pipeline.
module sssf_obuf import sssf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  out_beat_t             din,
	input  logic                  pop,
	output out_beat_t             dout,
	output logic                  not_empty,
	output logic [OBUF_CNT_W-1:0] cnt
);

	out_beat_t               fifo_q [OBUF_DEPTH];
	logic [OBUF_PTR_W-1:0]   wr_ptr_q;
	logic [OBUF_PTR_W-1:0]   rd_ptr_q;
	logic [OBUF_CNT_W-1:0]   cnt_q;

	assign dout      = fifo_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign cnt       = cnt_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= din;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + OBUF_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OBUF_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + OBUF_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - OBUF_CNT_W'(1);
		end
	end

endmodule

@@ src/sssf_checker.sv @@
// Port-level checks for the seven-segment scan block, bound to the top level.
module sssf_checker import sssf_pkg::*; #(
	parameter int MAX_DIGITS = 8
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// A stalled result beat holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A tick taken with the output idle shows up after the stage-1 register and the output buffer
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_TICK && !m_tvalid |=> ##1 m_tvalid)
		else $error("tick result missing");

	// The selected digit is always inside the store
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (MAX_DIGITS > 8) || (32'(m_tdata[10:8]) < MAX_DIGITS))
		else $error("digit select out of range");

	// No result right after reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result valid out of reset");

endmodule

bind seven_segment_scan_flash sssf_checker #(.MAX_DIGITS(MAX_DIGITS)) u_sssf_checker (.*);

@@ tb/tb_seven_segment_scan_flash.sv @@
// Self-checking testbench for the seven-segment scan and flash controller.
module tb_seven_segment_scan_flash;
	import sssf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIGITS      = 8;
	localparam int SETTLE_CYC  = 6;       // idle margin after the last owed beat has come out
	localparam int LIMIT_NS    = 6000000;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;    // [2:0] digit_position, [6:3] bcd_value, [7] start_number
	logic [1:0]            s_tuser;    // [1:0] operation
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;    // [7:0] segments, [10:8] digit_select, [15:11] zero
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Tracks the display state and the scan beats still owed by the block
	class display_scoreboard;
		logic [SEG_W-1:0]    patterns [DIGITS];
		int unsigned         cur_digit;
		int unsigned         flash_scans;
		logic [DCOUNT_W-1:0] n_digits_reg;
		logic [POS_W-1:0]    blink_lo;
		logic [POS_W-1:0]    blink_hi;
		logic [PERIOD_W-1:0] blink_period;
		out_beat_t           scans_due [$];
		int                  errors;
		int                  commands;
		int                  beats_checked;
		int                  blanked;
		int                  reg_writes;

		function new();
			foreach (patterns[i]) patterns[i] = SEG_BLANK;
			n_digits_reg = DCOUNT_W'(DCOUNT_RST);
			blink_lo     = '0;
			blink_hi     = '0;
			blink_period = '0;
			flash_scans  = 0;
			cur_digit    = digits_used() - 1;
			errors = 0; commands = 0; beats_checked = 0; blanked = 0; reg_writes = 0;
		endfunction

		// Register value clamped to 1..DIGITS
		function int unsigned digits_used();
			if (n_digits_reg == 0) return 1;
			if (32'(n_digits_reg) > DIGITS) return DIGITS;
			return 32'(n_digits_reg);
		endfunction

		function logic [SEG_W-1:0] bcd_pattern(logic [BCD_W-1:0] bcd);
			case (bcd)
				4'd0: return 8'h3F;
				4'd1: return 8'h06;
				4'd2: return 8'h5B;
				4'd3: return 8'h4F;
				4'd4: return 8'h66;
				4'd5: return 8'h6D;
				4'd6: return 8'h7D;
				4'd7: return 8'h07;
				4'd8: return 8'h7F;
				4'd9: return 8'h67;
				default: return 8'h00;
			endcase
		endfunction

		function void write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			reg_writes++;
			case (idx)
				REG_DIGIT_COUNT: begin
					n_digits_reg = val[DCOUNT_W-1:0];
					cur_digit    = digits_used() - 1;
				end
				REG_FLASH_FIRST: blink_lo = val[POS_W-1:0];
				REG_FLASH_LAST:  blink_hi = val[POS_W-1:0];
				REG_FLASH_PERIOD: begin
					blink_period = val[PERIOD_W-1:0];
					flash_scans  = 0;
				end
				default: ;
			endcase
		endfunction

		// Apply one accepted command; a tick queues the beat it must produce
		function void take_command(op_t op, logic [POS_W-1:0] pos, logic [BCD_W-1:0] bcd,
				logic start);
			int unsigned n;
			int unsigned nxt;
			int unsigned per;
			out_beat_t   beat;
			commands++;
			n   = digits_used();
			per = 32'(blink_period);
			case (op)
				OP_WRITE: begin
					if (start) foreach (patterns[i]) patterns[i] = SEG_BLANK;
					if (32'(pos) < n) patterns[pos] = bcd_pattern(bcd);
				end
				OP_TOGGLE: patterns[pos] = patterns[pos] ^ DOT_BIT;
				OP_TICK: begin
					nxt = cur_digit + 1;
					if (nxt >= n) nxt = 0;
					cur_digit = nxt;
					beat.seg  = patterns[nxt];
					beat.sel  = nxt[SEL_W-1:0];
					if (per != 0) begin
						if (nxt == 0) flash_scans = (flash_scans + 1) % per;
						if (nxt >= 32'(blink_lo) && nxt <= 32'(blink_hi) &&
								flash_scans > (per / 2)) begin
							beat.seg = SEG_BLANK;
							blanked++;
						end
					end
					scans_due.push_back(beat);
				end
				default: ;
			endcase
		endfunction

		function void check_scan_beat(logic [15:0] data);
			out_beat_t want;
			if (scans_due.size() == 0) begin
				errors++;
				$display("%0t: scan beat with none due, expected none actual %h", $time,
					data);
				return;
			end
			want = scans_due.pop_front();
			beats_checked++;
			if (data[7:0] !== want.seg) begin
				errors++;
				$display("%0t: segments mismatch, expected %h actual %h", $time, want.seg,
					data[7:0]);
			end
			if (data[10:8] !== want.sel) begin
				errors++;
				$display("%0t: digit_select mismatch, expected %0d actual %0d", $time,
					want.sel, data[10:8]);
			end
			if (data[15:11] !== 5'd0) begin
				errors++;
				$display("%0t: tdata padding mismatch, expected 0 actual %h", $time,
					data[15:11]);
			end
		endfunction

		function int owed();
			return scans_due.size();
		endfunction
	endclass

	display_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	int in_stall_cycles;

	seven_segment_scan_flash dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

	// Input beat monitor
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.take_command(op_t'(s_tuser), s_tdata[2:0], s_tdata[6:3], s_tdata[7]);
		if (arst_n && s_tvalid && !s_tready)
			in_stall_cycles++;
	end

	// Output beat monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_scan_beat(m_tdata);
	end

	// Receiver: random stalls plus an optional long hold-off
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offer one command and hold it until accepted; returns at a falling edge
	task automatic send_cmd(op_t op, logic [POS_W-1:0] pos, logic [BCD_W-1:0] bcd,
			logic start);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {start, bcd, pos};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Random command, positions mostly inside the scanned range
	task automatic send_random_cmd();
		int unsigned r;
		op_t         op;
		int unsigned pos;
		r = $urandom_range(99);
		if (r < 34)      op = OP_WRITE;
		else if (r < 49) op = OP_TOGGLE;
		else if (r < 95) op = OP_TICK;
		else             op = OP_NONE;
		if ($urandom_range(3) == 0) pos = $urandom_range(DIGITS - 1);
		else                        pos = $urandom_range(sb.digits_used() - 1);
		send_cmd(op, POS_W'(pos), BCD_W'($urandom_range(15)), $urandom_range(9) == 0);
	endtask

	// Stop offering and wait until every owed beat has come out
	task automatic wait_all_scans();
		s_tvalid <= 1'b0;
		while (sb.owed() != 0) @(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	// One register beat; caller lowers cfg_valid
	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
	endtask

	// Program all registers, then run a stretch of random commands
	task automatic run_phase(int unsigned count, int unsigned first, int unsigned last,
			int unsigned period, int send_idle, int recv_stall, int n);
		logic [15:0] junk;
		wait_all_scans();
		junk = 16'($urandom);
		write_reg(REG_DIGIT_COUNT, {junk[15:4], 4'(count)});
		write_reg(REG_FLASH_FIRST, {junk[12:0], 3'(first)});
		write_reg(REG_FLASH_LAST, {junk[15:3], 3'(last)});
		write_reg(REG_FLASH_PERIOD, 16'(period));
		cfg_valid <= 1'b0;
		send_idle_pct  = send_idle;
		recv_stall_pct = recv_stall;
		for (int i = 0; i < n; i++) begin
			// sender pause halfway through
			if (i == n / 2) wait_all_scans();
			send_random_cmd();
		end
		wait_all_scans();
	endtask

	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = OP_NONE;
		cfg_valid       = 1'b0;
		cfg_index       = REG_DIGIT_COUNT;
		cfg_data        = '0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 0;
		in_stall_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: every digit code, blanks, clears, dots, ignored code, full scan
		send_cmd(OP_WRITE, 0, 0, 1'b1);
		for (int p = 1; p < DIGITS; p++) send_cmd(OP_WRITE, POS_W'(p), BCD_W'(p), 1'b0);
		send_cmd(OP_WRITE, 0, 8, 1'b0);
		send_cmd(OP_WRITE, 1, 9, 1'b0);
		send_cmd(OP_WRITE, 2, 15, 1'b0);
		send_cmd(OP_WRITE, 3, 10, 1'b0);
		send_cmd(OP_TOGGLE, 7, 0, 1'b0);
		send_cmd(OP_TOGGLE, 0, 15, 1'b1);
		send_cmd(OP_NONE, 5, 9, 1'b1);
		for (int k = 0; k < DIGITS; k++) send_cmd(OP_TICK, 7, 15, 1'b1);
		send_cmd(OP_WRITE, 0, 5, 1'b1);
		send_cmd(OP_TICK, 0, 0, 1'b0);
		send_cmd(OP_TICK, 0, 0, 1'b0);
		wait_all_scans();

		// Receiver holds off while ticks keep coming, so the input must stall
		hold_off_cycles = 150;
		for (int k = 0; k < 40; k++) send_cmd(OP_TICK, POS_W'(k), BCD_W'(k), k[0]);
		wait_all_scans();

		run_phase(8, 0, 7, 3, 0, 0, 220);
		run_phase(1, 0, 0, 1, 71, 0, 200);
		run_phase(4, 1, 2, 5, 0, 71, 220);
		run_phase(0, 0, 7, 0, 15, 15, 200);
		run_phase(15, 7, 7, 65535, 0, 0, 220);
		run_phase(5, 3, 1, 4, 71, 0, 220);
		run_phase(8, 0, 7, 2, 0, 71, 200);
		run_phase(7, 2, 6, 3, 15, 15, 220);

		$display("covered %0d commands and %0d scan beats (%0d blanked by flashing)",
			sb.commands, sb.beats_checked, sb.blanked);
		$display("with %0d register writes and %0d cycles of input backpressure",
			sb.reg_writes, in_stall_cycles);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
src/sssf_pkg.sv
src/sssf_ctrl.sv
src/sssf_store.sv
src/sssf_obuf.sv
src/seven_segment_scan_flash.sv
src/sssf_checker.sv
tb/tb_seven_segment_scan_flash.sv
